FILE: rtl/vpu_pkg.sv
// Shared constants, types and the arctangent table of the vortex particle update.
package vpu_pkg;

  // Rotation iterations and quotient bits of the life ratio
  localparam int CORDIC_STEPS = 16;
  localparam int DIV_STEPS    = 16;
  localparam int NUM_CELLS    = (CORDIC_STEPS > DIV_STEPS) ? CORDIC_STEPS : DIV_STEPS;
  localparam int IDX_W        = $clog2(NUM_CELLS);

  // Angle constants, Q30
  localparam logic [38:0]        TWO_PI_U    = 39'd6746518852;
  localparam logic [38:0]        ANG_BIAS    = 39'd215888603264;  // 32 turns
  localparam logic signed [33:0] TWO_PI_S    = 34'sd6746518852;
  localparam logic signed [33:0] PI_S        = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_S   = 34'sd1686629713;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ROT_SPEED = 2'd0,
    REG_UP_SPEED  = 2'd1,
    REG_GROWTH    = 2'd2
  } cfg_reg_e;

  // One input beat
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [31:0]        age;
    logic [31:0]        lifetime;
    logic [15:0]        time_step;
  } in_t;

  // Particle as it travels through the front stages and the cell row
  typedef struct packed {
    logic signed [32:0] rx;
    logic signed [32:0] ry;
    logic signed [32:0] rz;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [31:0]        age;
    logic [31:0]        life;
    logic               full;   // life ratio pinned to one
    logic signed [32:0] aprod;
    logic signed [48:0] rprod;
    logic signed [32:0] rise;
    logic [38:0]        ang;
    logic signed [33:0] zr;
    logic               flip;
    logic signed [32:0] xc;
    logic signed [32:0] yc;
    logic [32:0]        rem;
    logic [15:0]        quo;
  } item_t;

  // atan(2^-i) in Q30
  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] a;
    case (i)
      5'd0:  a = 34'sd843314857;
      5'd1:  a = 34'sd497837829;
      5'd2:  a = 34'sd263043837;
      5'd3:  a = 34'sd133525159;
      5'd4:  a = 34'sd67021687;
      5'd5:  a = 34'sd33543516;
      5'd6:  a = 34'sd16775851;
      5'd7:  a = 34'sd8388437;
      5'd8:  a = 34'sd4194283;
      5'd9:  a = 34'sd2097149;
      5'd10: a = 34'sd1048576;
      5'd11: a = 34'sd524288;
      5'd12: a = 34'sd262144;
      5'd13: a = 34'sd131072;
      5'd14: a = 34'sd65536;
      5'd15: a = 34'sd32768;
      5'd16: a = 34'sd16384;
      5'd17: a = 34'sd8192;
      5'd18: a = 34'sd4096;
      5'd19: a = 34'sd2048;
      5'd20: a = 34'sd1024;
      5'd21: a = 34'sd512;
      5'd22: a = 34'sd256;
      5'd23: a = 34'sd128;
      5'd24: a = 34'sd64;
      5'd25: a = 34'sd32;
      5'd26: a = 34'sd16;
      5'd27: a = 34'sd8;
      5'd28: a = 34'sd4;
      5'd29: a = 34'sd2;
      5'd30: a = 34'sd1;
      default: a = 34'sd0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/vpu_front.sv
// Front stages: offsets, angle product, angle reduction to [-pi/2, pi/2], cell row setup.
module vpu_front import vpu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  in_t                in_i,
  input  logic signed [15:0] rot_speed_i,
  input  logic signed [31:0] up_speed_i,
  output logic               valid_o,
  output item_t              item_o
);

  localparam int RED_STEPS = 6;
  localparam int NSTG      = RED_STEPS + 3;

  item_t s0_d, s0_q, s1_d, s1_q, fo_d, fo_q;
  item_t red_d [RED_STEPS];
  item_t red_q [RED_STEPS];
  logic [NSTG-1:0] vld_q;

  // Stage 0: offsets from the centre and the two time-step products
  always_comb begin
    s0_d       = '0;
    s0_d.rx    = 33'(in_i.pos_x) - 33'(in_i.center_x);
    s0_d.ry    = 33'(in_i.pos_y) - 33'(in_i.center_y);
    s0_d.rz    = 33'(in_i.pos_z) - 33'(in_i.center_z);
    s0_d.cx    = in_i.center_x;
    s0_d.cy    = in_i.center_y;
    s0_d.cz    = in_i.center_z;
    s0_d.age   = in_i.age;
    s0_d.life  = in_i.lifetime;
    s0_d.full  = (in_i.lifetime == 32'd0) || (in_i.age >= in_i.lifetime);
    s0_d.aprod = $signed(rot_speed_i) * $signed({1'b0, in_i.time_step});
    s0_d.rprod = $signed(up_speed_i) * $signed({1'b0, in_i.time_step});
  end

  // Stage 1: angle to Q30, made non-negative; rounded rise
  always_comb begin
    s1_d      = s0_q;
    s1_d.ang  = {s0_q.aprod[32:0], 6'b0};
    if (s0_q.aprod < 0) begin
      s1_d.ang = s1_d.ang + ANG_BIAS;
    end
    s1_d.rise = 33'((s0_q.rprod + 49'sd32768) >>> 16);
  end

  // Reduction modulo 2pi, one multiple of 2pi per stage
  for (genvar k = 0; k < RED_STEPS; k++) begin : g_red
    item_t       src;
    logic [38:0] step;
    assign src  = (k == 0) ? s1_q : red_q[(k == 0) ? 0 : k - 1];
    assign step = TWO_PI_U << (RED_STEPS - 1 - k);
    always_comb begin
      red_d[k] = src;
      if (src.ang >= step) begin
        red_d[k].ang = src.ang - step;
      end
    end
  end

  // Wrap to [-pi, pi), fold into [-pi/2, pi/2], set up cell row
  always_comb begin
    logic signed [33:0] r;
    fo_d = red_q[RED_STEPS-1];
    r    = $signed({1'b0, red_q[RED_STEPS-1].ang[32:0]});
    if (r >= PI_S) begin
      r = r - TWO_PI_S;
    end
    fo_d.flip = 1'b0;
    if (r > HALF_PI_S) begin
      r         = r - PI_S;
      fo_d.flip = 1'b1;
    end else if (r < -HALF_PI_S) begin
      r         = r + PI_S;
      fo_d.flip = 1'b1;
    end
    fo_d.zr  = r;
    fo_d.xc  = CORDIC_GAIN;
    fo_d.yc  = '0;
    fo_d.rem = {1'b0, red_q[RED_STEPS-1].age};
    fo_d.quo = '0;
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_q <= s0_d;
      s1_q <= s1_d;
      for (int k = 0; k < RED_STEPS; k++) begin
        red_q[k] <= red_d[k];
      end
      fo_q <= fo_d;
    end
  end

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTG-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[NSTG-1];
  assign item_o  = fo_q;

endmodule

FILE: rtl/vpu_cell.sv
// One cell of the row: a CORDIC rotation step and a restoring divide step.
module vpu_cell import vpu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [IDX_W-1:0] idx_i,
  input  logic             valid_i,
  input  item_t            item_i,
  output logic             valid_o,
  output item_t            item_o
);

  item_t it_d, it_q;
  logic  valid_q;

  always_comb begin
    logic [32:0] r2;
    it_d = item_i;
    r2   = {item_i.rem[31:0], 1'b0};
    // rotation toward zero residual angle
    if (32'(idx_i) < CORDIC_STEPS) begin
      if (item_i.zr >= 0) begin
        it_d.xc = item_i.xc - (item_i.yc >>> idx_i);
        it_d.yc = item_i.yc + (item_i.xc >>> idx_i);
        it_d.zr = item_i.zr - atan_q30(5'(idx_i));
      end else begin
        it_d.xc = item_i.xc + (item_i.yc >>> idx_i);
        it_d.yc = item_i.yc - (item_i.xc >>> idx_i);
        it_d.zr = item_i.zr + atan_q30(5'(idx_i));
      end
    end
    // one quotient bit of age / lifetime
    if (32'(idx_i) < DIV_STEPS) begin
      if (r2 >= {1'b0, item_i.life}) begin
        it_d.rem = r2 - {1'b0, item_i.life};
        it_d.quo = {item_i.quo[14:0], 1'b1};
      end else begin
        it_d.rem = r2;
        it_d.quo = {item_i.quo[14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it_q <= it_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = it_q;

endmodule

FILE: rtl/vpu_back.sv
// Back stages: rotation, growth scale, recentring, saturation and the output register.
module vpu_back import vpu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  item_t              item_i,
  input  logic signed [15:0] growth_i,
  output logic               valid_o,
  output logic signed [31:0] new_x_o,
  output logic signed [31:0] new_y_o,
  output logic signed [31:0] new_z_o,
  output logic               saturated_o
);

  localparam int NSTG = 6;

  logic [NSTG-1:0] vld_q;

  // b0
  logic signed [32:0] b0_rx_q, b0_ry_q, b0_rz_q, b0_c_q, b0_s_q, b0_rise_q;
  logic signed [31:0] b0_ctr_q [3];
  logic signed [33:0] b0_sprod_q;
  // b1
  logic signed [65:0] b1_pxc_q, b1_pzs_q, b1_pxs_q, b1_pzc_q;
  logic signed [32:0] b1_ry_q, b1_rise_q;
  logic signed [24:0] b1_scale_q;
  logic signed [31:0] b1_ctr_q [3];
  // b2..b5 per axis lanes
  logic signed [34:0] b2_t_q [3];
  logic signed [24:0] b2_scale_q;
  logic signed [32:0] b2_rise_q, b3_rise_q, b4_rise_q;
  logic signed [31:0] b2_ctr_q [3];
  logic signed [31:0] b3_ctr_q [3];
  logic signed [31:0] b4_ctr_q [3];
  logic signed [43:0] b3_ph_q [3];
  logic signed [41:0] b3_pl_q [3];
  logic signed [44:0] b4_v_q [3];
  logic signed [46:0] b5_sum_q [3];

  logic signed [31:0] sat_d [3];
  logic [2:0]         clip_d;
  logic               out_vld_q;
  logic signed [31:0] out_q [3];
  logic               out_sat_q;

  // saturate each coordinate to 32 bits
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (b5_sum_q[a] > 47'sd2147483647) begin
        sat_d[a]  = 32'sh7FFFFFFF;
        clip_d[a] = 1'b1;
      end else if (b5_sum_q[a] < -47'sd2147483648) begin
        sat_d[a]  = 32'sh80000000;
        clip_d[a] = 1'b1;
      end else begin
        sat_d[a]  = 32'(b5_sum_q[a]);
        clip_d[a] = 1'b0;
      end
    end
  end

  // payload pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // b0: signed sine and cosine, ratio times growth
      b0_rx_q    <= item_i.rx;
      b0_ry_q    <= item_i.ry;
      b0_rz_q    <= item_i.rz;
      b0_rise_q  <= item_i.rise;
      b0_ctr_q[0] <= item_i.cx;
      b0_ctr_q[1] <= item_i.cy;
      b0_ctr_q[2] <= item_i.cz;
      b0_c_q     <= item_i.flip ? -item_i.xc : item_i.xc;
      b0_s_q     <= item_i.flip ? -item_i.yc : item_i.yc;
      b0_sprod_q <= $signed({1'b0, (item_i.full ? 17'd65536 : {1'b0, item_i.quo})}) *
                    growth_i;
      // b1: rotation products, scale
      b1_pxc_q   <= b0_rx_q * b0_c_q;
      b1_pzs_q   <= b0_rz_q * b0_s_q;
      b1_pxs_q   <= b0_rx_q * b0_s_q;
      b1_pzc_q   <= b0_rz_q * b0_c_q;
      b1_scale_q <= 25'((b0_sprod_q + 34'sd128) >>> 8) + 25'sd65536;
      b1_ry_q    <= b0_ry_q;
      b1_rise_q  <= b0_rise_q;
      b1_ctr_q   <= b0_ctr_q;
      // b2: rotated offsets to Q16.16
      b2_t_q[0]  <= 35'((b1_pxc_q - b1_pzs_q + 66'sd536870912) >>> 30);
      b2_t_q[1]  <= 35'(b1_ry_q);
      b2_t_q[2]  <= 35'((b1_pxs_q + b1_pzc_q + 66'sd536870912) >>> 30);
      b2_scale_q <= b1_scale_q;
      b2_rise_q  <= b1_rise_q;
      b2_ctr_q   <= b1_ctr_q;
      // b3: offset times scale as high and low partial products
      for (int a = 0; a < 3; a++) begin
        b3_ph_q[a] <= $signed(b2_t_q[a][34:16]) * b2_scale_q;
        b3_pl_q[a] <= $signed({1'b0, b2_t_q[a][15:0]}) * b2_scale_q;
      end
      b3_rise_q <= b2_rise_q;
      b3_ctr_q  <= b2_ctr_q;
      // b4: combine partials with rounding
      for (int a = 0; a < 3; a++) begin
        b4_v_q[a] <= 45'(b3_ph_q[a]) + 45'((b3_pl_q[a] + 42'sd32768) >>> 16);
      end
      b4_rise_q <= b3_rise_q;
      b4_ctr_q  <= b3_ctr_q;
      // b5: back to the centre, rise on y
      b5_sum_q[0] <= 47'(b4_ctr_q[0]) + 47'(b4_v_q[0]);
      b5_sum_q[1] <= 47'(b4_ctr_q[1]) + 47'(b4_v_q[1]) + 47'(b4_rise_q);
      b5_sum_q[2] <= 47'(b4_ctr_q[2]) + 47'(b4_v_q[2]);
      // output register
      out_q     <= sat_d;
      out_sat_q <= |clip_d;
    end
  end

  // valid chain and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[NSTG-2:0], valid_i};
      out_vld_q <= vld_q[NSTG-1];
    end
  end

  assign valid_o     = out_vld_q;
  assign new_x_o     = out_q[0];
  assign new_y_o     = out_q[1];
  assign new_z_o     = out_q[2];
  assign saturated_o = out_sat_q;

endmodule

FILE: rtl/vortex_particle_update.sv
// Top level of the vortex particle update: config registers, front, cell row, back.
// Takes one particle beat per clock and returns one result beat per particle, in order.
// The path is a single pipeline: nine front stages (offsets, angle reduction), a row of
// NUM_CELLS cells (one CORDIC rotation and one quotient bit each), six back stages and the
// output register. The whole pipeline advances whenever the output register is empty or
// being taken; a held result stalls every stage and in_ready_o drops with it.
// Configuration writes are taken at any time and should be made while no particle is in
// flight.
module vortex_particle_update import vpu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  // particle in
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic [31:0]        age_i,
  input  logic [31:0]        lifetime_i,
  input  logic [15:0]        time_step_i,
  // result out
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] new_x_o,
  output logic signed [31:0] new_y_o,
  output logic signed [31:0] new_z_o,
  output logic               saturated_o
);

  logic signed [15:0] rot_speed_q;
  logic signed [31:0] up_speed_q;
  logic signed [15:0] growth_q;
  logic               en;
  in_t                in_d;

  logic  cell_vld [NUM_CELLS+1];
  item_t cell_it  [NUM_CELLS+1];

  // config registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_speed_q <= '0;
      up_speed_q  <= '0;
      growth_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ROT_SPEED: rot_speed_q <= cfg_data_i[15:0];
        REG_UP_SPEED:  up_speed_q  <= cfg_data_i;
        REG_GROWTH:    growth_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    in_d.pos_x     = pos_x_i;
    in_d.pos_y     = pos_y_i;
    in_d.pos_z     = pos_z_i;
    in_d.center_x  = center_x_i;
    in_d.center_y  = center_y_i;
    in_d.center_z  = center_z_i;
    in_d.age       = age_i;
    in_d.lifetime  = lifetime_i;
    in_d.time_step = time_step_i;
  end

  vpu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_valid_i),
    .in_i        (in_d),
    .rot_speed_i (rot_speed_q),
    .up_speed_i  (up_speed_q),
    .valid_o     (cell_vld[0]),
    .item_o      (cell_it[0])
  );

  // cell row
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    vpu_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .idx_i   (IDX_W'(g)),
      .valid_i (cell_vld[g]),
      .item_i  (cell_it[g]),
      .valid_o (cell_vld[g+1]),
      .item_o  (cell_it[g+1])
    );
  end

  vpu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (cell_vld[NUM_CELLS]),
    .item_i      (cell_it[NUM_CELLS]),
    .growth_i    (growth_q),
    .valid_o     (out_valid_o),
    .new_x_o     (new_x_o),
    .new_y_o     (new_y_o),
    .new_z_o     (new_z_o),
    .saturated_o (saturated_o)
  );

endmodule

FILE: verif/vpu_checker.sv
// Scoreboard for the vortex particle update: predicts each particle and checks every result beat.
module vpu_checker import vpu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic [31:0]        age_i,
  input  logic [31:0]        lifetime_i,
  input  logic [15:0]        time_step_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] new_x_i,
  input  logic signed [31:0] new_y_i,
  input  logic signed [31:0] new_z_i,
  input  logic               saturated_i,
  output int                 errors_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint TURN_Q30      = 64'sd6746518852;
  localparam longint HALF_TURN_Q30 = 64'sd3373259426;
  localparam longint QUARTER_Q30   = 64'sd1686629713;
  localparam longint START_X_Q30   = 64'sd652032874;
  localparam int     ROT_ITERS     = (CORDIC_STEPS > 31) ? 31 : CORDIC_STEPS;
  localparam longint ARCTAN [31] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
    131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
    128, 64, 32, 16, 8, 4, 2, 1};

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               sat;
  } position_t;

  // local copy of the config registers
  logic signed [15:0] spin_rate;
  logic signed [31:0] lift_rate;
  logic signed [15:0] growth;

  position_t expected_pos[$];
  int        err_cnt;

  assign errors_o  = err_cnt;
  assign pending_o = expected_pos.size();

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clip32(longint v, ref bit clipped);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // rotate the offset, scale it by one plus the life ratio times growth, lift y, then recentre and clip
  function automatic position_t move_particle(in_t p);
    longint    r, x, y, nx, sn, cs, dx, dy, dz, tx, tz, ratio, scale, rise, age, life;
    bit        flip, clipped;
    position_t res;
    r = (longint'(spin_rate) * longint'(p.time_step) * 64) % TURN_Q30;
    if (r < 0) r += TURN_Q30;
    if (r >= HALF_TURN_Q30) r -= TURN_Q30;
    flip = 1'b0;
    if (r > QUARTER_Q30) begin
      r -= HALF_TURN_Q30;
      flip = 1'b1;
    end else if (r < -QUARTER_Q30) begin
      r += HALF_TURN_Q30;
      flip = 1'b1;
    end
    x = START_X_Q30;
    y = 0;
    for (int i = 0; i < ROT_ITERS; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        r -= ARCTAN[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        r += ARCTAN[i];
      end
      x = nx;
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
    dx = longint'(p.pos_x) - longint'(p.center_x);
    dy = longint'(p.pos_y) - longint'(p.center_y);
    dz = longint'(p.pos_z) - longint'(p.center_z);
    tx = rnd_shift(dx * cs - dz * sn, 30);
    tz = rnd_shift(dx * sn + dz * cs, 30);
    age  = longint'(p.age);
    life = longint'(p.lifetime);
    if (life == 0 || age >= life) ratio = 65536;
    else ratio = (age << 16) / life;
    scale = 65536 + rnd_shift(ratio * longint'(growth), 8);
    tx = rnd_shift(tx * scale, 16);
    dy = rnd_shift(dy * scale, 16);
    tz = rnd_shift(tz * scale, 16);
    rise = rnd_shift(longint'(lift_rate) * longint'(p.time_step), 16);
    clipped = 1'b0;
    res.x   = clip32(longint'(p.center_x) + tx, clipped);
    res.y   = clip32(longint'(p.center_y) + dy + rise, clipped);
    res.z   = clip32(longint'(p.center_z) + tz, clipped);
    res.sat = clipped;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  initial err_cnt = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    in_t       beat;
    position_t want;
    if (!rst_ni) begin
      spin_rate <= '0;
      lift_rate <= '0;
      growth    <= '0;
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_ROT_SPEED: spin_rate <= cfg_data_i[15:0];
          REG_UP_SPEED:  lift_rate <= cfg_data_i;
          REG_GROWTH:    growth    <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      // accepted particle beat
      if (in_valid_i && in_ready_i) begin
        beat.pos_x     = pos_x_i;
        beat.pos_y     = pos_y_i;
        beat.pos_z     = pos_z_i;
        beat.center_x  = center_x_i;
        beat.center_y  = center_y_i;
        beat.center_z  = center_z_i;
        beat.age       = age_i;
        beat.lifetime  = lifetime_i;
        beat.time_step = time_step_i;
        expected_pos.push_back(move_particle(beat));
      end
      // result beat
      if (out_valid_i && out_ready_i) begin
        if (expected_pos.size() == 0) begin
          $display("%0t ns: result beat with nothing expected", $time);
          err_cnt++;
        end else begin
          want = expected_pos.pop_front();
          if (new_x_i != want.x) report_mismatch("new_x", new_x_i, want.x);
          if (new_y_i != want.y) report_mismatch("new_y", new_y_i, want.y);
          if (new_z_i != want.z) report_mismatch("new_z", new_z_i, want.z);
          if (saturated_i != want.sat) report_mismatch("saturated", saturated_i, want.sat);
        end
      end
    end
  end

endmodule

FILE: verif/testbench.sv
// Top of the vortex particle update testbench: clock, reset, stimulus and verdict.
module testbench import vpu_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = NUM_CELLS + 24;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_valid, cfg_ready;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid, in_ready;
  logic signed [31:0] pos_x, pos_y, pos_z, center_x, center_y, center_z;
  logic [31:0]        age, lifetime;
  logic [15:0]        time_step;
  logic               out_valid, out_ready;
  logic signed [31:0] new_x, new_y, new_z;
  logic               saturated;
  int                 errors, pending;

  int sent_cnt = 0;     // particle beats accepted, sender side
  int taken_cnt = 0;    // result beats taken, receiver side
  int hold_cnt = 0;
  bit held_once = 0;

  always #5 clk = ~clk;

  vortex_particle_update u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .center_x_i(center_x), .center_y_i(center_y), .center_z_i(center_z),
    .age_i(age), .lifetime_i(lifetime), .time_step_i(time_step),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .new_x_o(new_x), .new_y_o(new_y), .new_z_o(new_z), .saturated_o(saturated)
  );

  vpu_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .center_x_i(center_x), .center_y_i(center_y), .center_z_i(center_z),
    .age_i(age), .lifetime_i(lifetime), .time_step_i(time_step),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .new_x_i(new_x), .new_y_i(new_y), .new_z_i(new_z), .saturated_i(saturated),
    .errors_o(errors), .pending_o(pending)
  );

  // result side: random stalls, one long hold-off, a calm window
  always @(posedge clk) begin
    if (out_valid && out_ready) taken_cnt <= taken_cnt + 1;
    if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (!held_once && taken_cnt == 300) begin
      held_once <= 1'b1;
      hold_cnt  <= 250;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (taken_cnt >= 550 && taken_cnt < 750) || ($urandom_range(99) >= 7);
    end
  end

  // watchdog
  initial begin
    #3ms;
    $display("*** FAILED ***");
    $finish;
  end

  // one register beat; the caller drops cfg_valid after the last one
  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_vortex(logic [15:0] spin, logic [31:0] lift, logic [15:0] grow);
    in_valid <= 1'b0;
    settle();
    write_reg(REG_ROT_SPEED, {16'h0, spin});
    write_reg(REG_UP_SPEED, lift);
    write_reg(REG_GROWTH, {16'h0, grow});
    cfg_valid <= 1'b0;
  endtask

  // one particle beat, with an occasional gap before it
  task automatic send_particle(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                               logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                               logic [31:0] ag, logic [31:0] lf, logic [15:0] dt);
    bit calm;
    calm = (sent_cnt >= 500 && sent_cnt < 700);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    pos_x     <= px;
    pos_y     <= py;
    pos_z     <= pz;
    center_x  <= cx;
    center_y  <= cy;
    center_z  <= cz;
    age       <= ag;
    lifetime  <= lf;
    time_step <= dt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_cnt++;
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return 32'($urandom_range(2097152)) - 32'd1048576;
      default: return 32'($urandom_range(33554432)) - 32'd16777216;
    endcase
  endfunction

  function automatic logic [31:0] pick_time();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return 32'd0;
      default: return $urandom_range(1 << 22);
    endcase
  endfunction

  task automatic send_random_particle();
    logic [31:0] cx, cy, cz, ag, lf;
    cx = pick_coord();
    cy = pick_coord();
    cz = pick_coord();
    ag = pick_time();
    lf = pick_time();
    if ($urandom_range(3) == 0)
      send_particle($urandom, $urandom, $urandom, cx, cy, cz, ag, lf, 16'($urandom));
    else
      send_particle(cx + pick_coord(), cy + pick_coord(), cz + pick_coord(), cx, cy, cz,
                    ag, lf, 16'($urandom));
  endtask

  task automatic directed_set();
    send_particle(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_particle(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  32'h7fffffff, 32'hffffffff, 32'hffffffff, 16'hffff);
    send_particle(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                  32'h80000000, 0, 32'hffffffff, 16'hffff);
    // extreme offsets both ways, so coordinates clip
    send_particle(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                  32'h80000000, 32'h10000, 32'h20000, 16'h8000);
    send_particle(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                  32'h7fffffff, 32'h10000, 32'h20000, 16'h0001);
    // zero lifetime, age past lifetime, age equal to lifetime
    send_particle(32'h30000, 32'h10000, -32'sh20000, 32'h10000, 0, 0, 32'h5000, 0, 16'h1000);
    send_particle(32'h30000, 32'h10000, -32'sh20000, 32'h10000, 0, 0, 32'h90000, 32'h40000,
                  16'h1000);
    send_particle(32'h30000, 32'h10000, -32'sh20000, 32'h10000, 0, 0, 32'h40000, 32'h40000,
                  16'h4000);
    send_particle(-32'sh50000, 32'h8000, 32'h70000, 32'h1000, 32'h2000, 32'h3000, 32'h1,
                  32'hffffffff, 16'h0);
    send_particle(-32'sh50000, 32'h8000, 32'h70000, 32'h1000, 32'h2000, 32'h3000, 32'h8000,
                  32'h10000, 16'hffff);
    send_particle(32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f, 32'h5555, 32'haaaa, 32'hf0f0,
                  32'haaaa5555, 32'h5555aaaa, 16'ha5a5);
  endtask

  initial begin
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ROT_SPEED;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    pos_x     <= '0;
    pos_y     <= '0;
    pos_z     <= '0;
    center_x  <= '0;
    center_y  <= '0;
    center_z  <= '0;
    age       <= '0;
    lifetime  <= '0;
    time_step <= '0;
    out_ready <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, then a rotating, rising, growing vortex, then a mirror
    directed_set();
    load_vortex(16'd3217, 32'h00018000, 16'h0100);
    directed_set();
    load_vortex(-16'sd3217, -32'sh20000, -16'sh0200);
    directed_set();

    // random phases, extremes first
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       load_vortex(16'h7fff, 32'h7fffffff, 16'h7fff);
        1:       load_vortex(16'h8000, 32'h80000000, 16'h8000);
        2:       load_vortex(16'h0000, 32'h00000000, 16'h0000);
        default: load_vortex(16'($urandom),
                             ($urandom_range(1) != 0) ? $urandom
                                                      : 32'($urandom_range(1 << 20)),
                             ($urandom_range(1) != 0) ? 16'($urandom)
                                                      : 16'($urandom_range(1024)) - 16'd512);
      endcase
      for (int k = 0; k < 125; k++) send_random_particle();
    end
    in_valid <= 1'b0;

    settle();
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/vpu_pkg.sv
rtl/vpu_front.sv
rtl/vpu_cell.sv
rtl/vpu_back.sv
rtl/vortex_particle_update.sv
verif/vpu_checker.sv
verif/testbench.sv
